[rtl/grid_cutoff_cell_range_assert.svh]
// assertion helpers for the cutoff cell range block
// both forms sample on clk and are switched off while arst_n is low
`ifndef GRID_CUTOFF_CELL_RANGE_ASSERT_SVH
`define GRID_CUTOFF_CELL_RANGE_ASSERT_SVH
`ifndef SYNTHESIS
// condition that must hold on every edge
`define GCCR_CHECK(name, expr) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("grid_cutoff_cell_range: check failed");
// condition that must hold on the edge after a trigger
`define GCCR_CHECK_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("grid_cutoff_cell_range: check failed");
`else
`define GCCR_CHECK(name, expr)
`define GCCR_CHECK_NEXT(name, ante, cons)
`endif
`endif

[rtl/gccr_pkg.sv]
`timescale 1ns / 1ps

package gccr_pkg;

	// field widths
	localparam int COORD_W   = 24;
	localparam int FRAC_BITS = 8;
	localparam int RADIUS_W  = 14;
	localparam int CPU_W     = 7;
	localparam int SIZE_W    = 11;
	localparam int CELL_W    = 11;
	localparam int AXIS_W    = 2;
	localparam int MAX_CELLS = 1024;

	// derived arithmetic widths
	localparam int DIFF_W     = COORD_W + 1;
	localparam int REST_W     = 2 * RADIUS_W;
	localparam int SQRT_STEPS = RADIUS_W;
	localparam int REL_W      = COORD_W + 2;
	localparam int PROD_W     = REL_W + CPU_W + 1;
	localparam int TRUNC_W    = PROD_W - FRAC_BITS;

	// configuration port
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	// queue depths
	localparam int MID_DEPTH_DEF = 8;
	localparam int OUT_DEPTH_DEF = 32;

	// axis codes
	localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
	localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
	localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

	// register indexes
	localparam logic [2:0] REG_CORNER_X = 3'd0;
	localparam logic [2:0] REG_CORNER_Y = 3'd1;
	localparam logic [2:0] REG_CORNER_Z = 3'd2;
	localparam logic [2:0] REG_CPU      = 3'd3;
	localparam logic [2:0] REG_SIZE_X   = 3'd4;
	localparam logic [2:0] REG_SIZE_Y   = 3'd5;
	localparam logic [2:0] REG_SIZE_Z   = 3'd6;

	// register reset values
	localparam logic [CPU_W-1:0]  CPU_RESET  = 7'd4;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

	// index markers for an empty chord
	localparam logic signed [CELL_W-1:0] FIRST_NONE = -11'sd1;
	localparam logic signed [CELL_W-1:0] LAST_NONE  = -11'sd2;

	typedef struct packed {
		logic signed [COORD_W-1:0] corner_x;
		logic signed [COORD_W-1:0] corner_y;
		logic signed [COORD_W-1:0] corner_z;
		logic [CPU_W-1:0]          cells_per_unit;
		logic [SIZE_W-1:0]         size_x;
		logic [SIZE_W-1:0]         size_y;
		logic [SIZE_W-1:0]         size_z;
	} cfg_t;

	// classified item between front and back
	typedef struct packed {
		logic                      empty;
		logic [REST_W-1:0]         rest;
		logic signed [COORD_W-1:0] q;
		logic [AXIS_W-1:0]         axis;
	} mid_t;

	typedef struct packed {
		logic                     empty;
		logic signed [CELL_W-1:0] first;
		logic signed [CELL_W-1:0] last;
	} out_t;

endpackage

[rtl/gccr_fifo.sv]
`timescale 1ns / 1ps

module gccr_fifo #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic [CW-1:0]    count,
	output logic             full,
	output logic             empty
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10: begin
					count_q <= count_q + 1'b1;
				end
				2'b01: begin
					count_q <= count_q - 1'b1;
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

endmodule

[rtl/gccr_front.sv]
`timescale 1ns / 1ps

module gccr_front #(
	parameter int MID_DEPTH = gccr_pkg::MID_DEPTH_DEF,
	localparam int MCW = $clog2(MID_DEPTH + 1)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic [gccr_pkg::AXIS_W-1:0]         axis_sel,
	input  logic signed [gccr_pkg::COORD_W-1:0] ref_x,
	input  logic signed [gccr_pkg::COORD_W-1:0] ref_y,
	input  logic signed [gccr_pkg::COORD_W-1:0] ref_z,
	input  logic signed [gccr_pkg::COORD_W-1:0] query_x,
	input  logic signed [gccr_pkg::COORD_W-1:0] query_y,
	input  logic signed [gccr_pkg::COORD_W-1:0] query_z,
	input  logic [gccr_pkg::RADIUS_W-1:0]       radius,
	input  logic [MCW-1:0]                      mid_count,
	output logic                                mid_push,
	output gccr_pkg::mid_t                      mid_data
);

	localparam int DW = gccr_pkg::DIFF_W;
	localparam int RW = gccr_pkg::RADIUS_W;
	localparam int SW = gccr_pkg::REST_W;

	logic                                accept;
	logic signed [gccr_pkg::COORD_W-1:0] ref_a, ref_b, qry_a, qry_b, q_sel;
	logic [gccr_pkg::AXIS_W-1:0]         axis_eff;

	logic                                v_s1;
	logic signed [DW-1:0]                diff_a_s1, diff_b_s1;
	logic [RW-1:0]                       radius_s1;
	logic signed [gccr_pkg::COORD_W-1:0] q_s1;
	logic [gccr_pkg::AXIS_W-1:0]         axis_s1;

	logic [DW-1:0]                       abs_a, abs_b;
	logic                                over_a, over_b;

	logic                                v_s2;
	logic                                over_s2;
	logic [SW-1:0]                       sq_a_s2, sq_b_s2, sq_r_s2;
	logic signed [gccr_pkg::COORD_W-1:0] q_s2;
	logic [gccr_pkg::AXIS_W-1:0]         axis_s2;

	logic [SW+1:0]                       rest;
	logic [MCW:0]                        fill;

	// room is counted over the queue and the two stages in front of it
	assign fill   = (MCW + 1)'(mid_count) + (MCW + 1)'(v_s1) + (MCW + 1)'(v_s2);
	assign full   = (fill >= (MCW + 1)'(MID_DEPTH));
	assign accept = push && !full;

	// pick the chosen axis and the two off-axis coordinates
	always_comb begin
		case (axis_sel)
			gccr_pkg::AXIS_X: begin
				ref_a = ref_y; qry_a = query_y;
				ref_b = ref_z; qry_b = query_z;
				q_sel = query_x; axis_eff = gccr_pkg::AXIS_X;
			end
			gccr_pkg::AXIS_Y: begin
				ref_a = ref_x; qry_a = query_x;
				ref_b = ref_z; qry_b = query_z;
				q_sel = query_y; axis_eff = gccr_pkg::AXIS_Y;
			end
			default: begin
				ref_a = ref_x; qry_a = query_x;
				ref_b = ref_y; qry_b = query_y;
				q_sel = query_z; axis_eff = gccr_pkg::AXIS_Z;
			end
		endcase
	end

	// stage 1: off-axis offsets
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		diff_a_s1 <= DW'(ref_a) - DW'(qry_a);
		diff_b_s1 <= DW'(ref_b) - DW'(qry_b);
		radius_s1 <= radius;
		q_s1      <= q_sel;
		axis_s1   <= axis_eff;
	end

	// magnitudes, and an offset beyond the radius empties the chord
	always_comb begin
		abs_a  = diff_a_s1[DW-1] ? -diff_a_s1 : diff_a_s1;
		abs_b  = diff_b_s1[DW-1] ? -diff_b_s1 : diff_b_s1;
		over_a = abs_a > DW'(radius_s1);
		over_b = abs_b > DW'(radius_s1);
	end

	// stage 2: squares
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		over_s2 <= over_a || over_b;
		sq_a_s2 <= abs_a[RW-1:0] * abs_a[RW-1:0];
		sq_b_s2 <= abs_b[RW-1:0] * abs_b[RW-1:0];
		sq_r_s2 <= radius_s1 * radius_s1;
		q_s2    <= q_s1;
		axis_s2 <= axis_s1;
	end

	// remainder and classification into the queue
	assign rest = (SW + 2)'(sq_r_s2) - (SW + 2)'(sq_a_s2) - (SW + 2)'(sq_b_s2);

	assign mid_push       = v_s2;
	assign mid_data.empty = over_s2 || rest[SW+1];
	assign mid_data.rest  = rest[SW-1:0];
	assign mid_data.q     = q_s2;
	assign mid_data.axis  = axis_s2;

endmodule

[rtl/gccr_back.sv]
`timescale 1ns / 1ps

module gccr_back #(
	parameter int OUT_DEPTH = gccr_pkg::OUT_DEPTH_DEF,
	localparam int OCW = $clog2(OUT_DEPTH + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  gccr_pkg::cfg_t cfg,
	input  logic           mid_empty,
	input  gccr_pkg::mid_t mid_data,
	output logic           mid_pop,
	input  logic [OCW-1:0] out_count,
	output logic           out_push,
	output gccr_pkg::out_t out_data
);

	localparam int STEPS = gccr_pkg::SQRT_STEPS;
	localparam int SW    = gccr_pkg::REST_W;
	localparam int RW    = gccr_pkg::RADIUS_W;
	localparam int LW    = gccr_pkg::REL_W;
	localparam int PW    = gccr_pkg::PROD_W;
	localparam int FB    = gccr_pkg::FRAC_BITS;
	localparam int TW    = gccr_pkg::TRUNC_W;
	localparam int CW    = gccr_pkg::CELL_W;
	localparam logic signed [PW-1:0] ROUND_UP = PW'((1 << FB) - 1);

	logic [OCW-1:0] inflight_q;
	logic [OCW:0]   owed;

	// square root pipeline, one result bit per stage
	logic                                sq_v_s     [STEPS+1];
	logic [SW-1:0]                       sq_rem_s   [STEPS+1];
	logic [SW-1:0]                       sq_res_s   [STEPS+1];
	logic                                sq_empty_s [STEPS+1];
	logic signed [gccr_pkg::COORD_W-1:0] sq_q_s     [STEPS+1];
	logic [gccr_pkg::AXIS_W-1:0]         sq_axis_s  [STEPS+1];

	logic [RW-1:0]                       half;
	logic signed [gccr_pkg::COORD_W-1:0] corner_sel;
	logic [gccr_pkg::SIZE_W-1:0]         size_sel;

	logic                        v_s1, empty_s1;
	logic signed [LW-1:0]        rel_lo_s1, rel_hi_s1;
	logic [gccr_pkg::AXIS_W-1:0] axis_s1, axis_s2, axis_s3;
	logic                        v_s2, empty_s2;
	logic signed [PW-1:0]        prod_lo_s2, prod_hi_s2;
	logic                        v_s3, empty_s3;
	logic signed [TW-1:0]        t_lo_s3, t_hi_s3;

	logic signed [PW-1:0] adj_lo, adj_hi;
	logic signed [TW:0]   lo_x, hi_x, top_x, lo_c, hi_c;

	// credit: pull only when the output queue can take everything in flight
	assign owed    = (OCW + 1)'(inflight_q) + (OCW + 1)'(out_count);
	assign mid_pop = !mid_empty && (owed < (OCW + 1)'(OUT_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			case ({mid_pop, out_push})
				2'b10: begin
					inflight_q <= inflight_q + 1'b1;
				end
				2'b01: begin
					inflight_q <= inflight_q - 1'b1;
				end
				default: begin
					inflight_q <= inflight_q;
				end
			endcase
		end
	end

	// load from the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v_s[0] <= 1'b0;
		end else begin
			sq_v_s[0] <= mid_pop;
		end
	end

	always_ff @(posedge clk) begin
		sq_rem_s[0]   <= mid_data.rest;
		sq_res_s[0]   <= '0;
		sq_empty_s[0] <= mid_data.empty;
		sq_q_s[0]     <= mid_data.q;
		sq_axis_s[0]  <= mid_data.axis;
	end

	// digit-by-digit square root
	for (genvar k = 0; k < STEPS; k++) begin : g_sqrt
		localparam logic [SW-1:0] ONE = SW'(1);
		localparam logic [SW-1:0] BIT = ONE << (2 * (STEPS - 1 - k));
		logic [SW-1:0] trial;
		logic          ge;

		assign trial = sq_res_s[k] + BIT;
		assign ge    = sq_rem_s[k] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[k+1] <= 1'b0;
			end else begin
				sq_v_s[k+1] <= sq_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			sq_rem_s[k+1]   <= ge ? sq_rem_s[k] - trial : sq_rem_s[k];
			sq_res_s[k+1]   <= ge ? (sq_res_s[k] >> 1) + BIT : sq_res_s[k] >> 1;
			sq_empty_s[k+1] <= sq_empty_s[k];
			sq_q_s[k+1]     <= sq_q_s[k];
			sq_axis_s[k+1]  <= sq_axis_s[k];
		end
	end

	assign half = sq_res_s[STEPS][RW-1:0];

	// grid parameters of the chosen axis
	always_comb begin
		case (sq_axis_s[STEPS])
			gccr_pkg::AXIS_X: begin
				corner_sel = cfg.corner_x;
			end
			gccr_pkg::AXIS_Y: begin
				corner_sel = cfg.corner_y;
			end
			default: begin
				corner_sel = cfg.corner_z;
			end
		endcase
		case (axis_s3)
			gccr_pkg::AXIS_X: begin
				size_sel = cfg.size_x;
			end
			gccr_pkg::AXIS_Y: begin
				size_sel = cfg.size_y;
			end
			default: begin
				size_sel = cfg.size_z;
			end
		endcase
	end

	// valid bits of the index mapping stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= sq_v_s[STEPS];
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage 1: chord ends relative to the grid corner
	always_ff @(posedge clk) begin
		rel_lo_s1 <= LW'(sq_q_s[STEPS]) - LW'(half) - LW'(corner_sel);
		rel_hi_s1 <= LW'(sq_q_s[STEPS]) + LW'(half) - LW'(corner_sel);
		empty_s1  <= sq_empty_s[STEPS];
		axis_s1   <= sq_axis_s[STEPS];
	end

	// stage 2: scale by cells per unit
	always_ff @(posedge clk) begin
		prod_lo_s2 <= PW'(rel_lo_s1) * PW'(signed'({1'b0, cfg.cells_per_unit}));
		prod_hi_s2 <= PW'(rel_hi_s1) * PW'(signed'({1'b0, cfg.cells_per_unit}));
		empty_s2   <= empty_s1;
		axis_s2    <= axis_s1;
	end

	// drop the fraction, truncating toward zero
	always_comb begin
		adj_lo = prod_lo_s2 + (prod_lo_s2[PW-1] ? ROUND_UP : '0);
		adj_hi = prod_hi_s2 + (prod_hi_s2[PW-1] ? ROUND_UP : '0);
	end

	// stage 3: truncated indices
	always_ff @(posedge clk) begin
		t_lo_s3  <= adj_lo[PW-1:FB];
		t_hi_s3  <= adj_hi[PW-1:FB];
		empty_s3 <= empty_s2;
		axis_s3  <= axis_s2;
	end

	// widen by one cell below and three above, clamp to the grid and the index range
	always_comb begin
		lo_x  = (TW + 1)'(t_lo_s3) - (TW + 1)'(1);
		hi_x  = (TW + 1)'(t_hi_s3) + (TW + 1)'(3);
		top_x = (TW + 1)'(signed'({1'b0, size_sel})) - (TW + 1)'(1);

		lo_c = lo_x;
		if (lo_x < 0) begin
			lo_c = '0;
		end else if (lo_x > (TW + 1)'(gccr_pkg::MAX_CELLS - 1)) begin
			lo_c = (TW + 1)'(gccr_pkg::MAX_CELLS - 1);
		end

		hi_c = (hi_x > top_x) ? top_x : hi_x;
		if (hi_c < -(TW + 1)'(2)) begin
			hi_c = -(TW + 1)'(2);
		end else if (hi_c > (TW + 1)'(gccr_pkg::MAX_CELLS - 1)) begin
			hi_c = (TW + 1)'(gccr_pkg::MAX_CELLS - 1);
		end
	end

	assign out_push       = v_s3;
	assign out_data.empty = empty_s3;
	assign out_data.first = empty_s3 ? gccr_pkg::FIRST_NONE : lo_c[CW-1:0];
	assign out_data.last  = empty_s3 ? gccr_pkg::LAST_NONE : hi_c[CW-1:0];

endmodule

[rtl/grid_cutoff_cell_range.sv]
// channel   direction  transfer on              payload
// input     in         push && !full            axis_sel, ref_x/y/z, query_x/y/z, radius
// result    out        pop && !empty            empty_range, first_cell, last_cell
// config    in/out     psel && penable && pwrite  paddr, pwdata, prdata (pready tied high)
//
// one item per cycle sustained when nothing stalls; results pass through the square root
// pipeline in the back end before the index mapping
// reset clears both queues and all stage valid bits and loads the register defaults
// with pop held low the result queue fills, the back end stops pulling from the
// middle queue, and full rises once the middle queue and front stages are taken
`timescale 1ns / 1ps
`include "grid_cutoff_cell_range_assert.svh"

module grid_cutoff_cell_range #(
	parameter int MID_DEPTH = gccr_pkg::MID_DEPTH_DEF,
	parameter int OUT_DEPTH = gccr_pkg::OUT_DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// input queue side
	input  logic                                 push,
	output logic                                 full,
	input  logic [gccr_pkg::AXIS_W-1:0]          axis_sel,
	input  logic signed [gccr_pkg::COORD_W-1:0]  ref_x,
	input  logic signed [gccr_pkg::COORD_W-1:0]  ref_y,
	input  logic signed [gccr_pkg::COORD_W-1:0]  ref_z,
	input  logic signed [gccr_pkg::COORD_W-1:0]  query_x,
	input  logic signed [gccr_pkg::COORD_W-1:0]  query_y,
	input  logic signed [gccr_pkg::COORD_W-1:0]  query_z,
	input  logic [gccr_pkg::RADIUS_W-1:0]        radius,
	// result queue side
	output logic                                 empty,
	input  logic                                 pop,
	output logic                                 empty_range,
	output logic signed [gccr_pkg::CELL_W-1:0]   first_cell,
	output logic signed [gccr_pkg::CELL_W-1:0]   last_cell,
	// configuration port
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [gccr_pkg::ADDR_W-1:0]          paddr,
	input  logic [gccr_pkg::DATA_W-1:0]          pwdata,
	output logic [gccr_pkg::DATA_W-1:0]          prdata,
	output logic                                 pready
);

	localparam int MCW = $clog2(MID_DEPTH + 1);
	localparam int OCW = $clog2(OUT_DEPTH + 1);
	localparam int MW  = $bits(gccr_pkg::mid_t);
	localparam int OW  = $bits(gccr_pkg::out_t);
	localparam int DW  = gccr_pkg::DATA_W;

	gccr_pkg::cfg_t cfg_q;
	logic           cfg_wr;
	logic [2:0]     reg_idx;

	logic           mid_push, mid_pop, mid_full, mid_empty;
	logic [MCW-1:0] mid_count;
	gccr_pkg::mid_t mid_wdata, mid_rdata;

	logic           out_push, out_full;
	logic [OCW-1:0] out_count;
	gccr_pkg::out_t out_wdata, out_rdata;

	// register file
	assign pready  = 1'b1;
	assign reg_idx = paddr[gccr_pkg::ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.corner_x       <= '0;
			cfg_q.corner_y       <= '0;
			cfg_q.corner_z       <= '0;
			cfg_q.cells_per_unit <= gccr_pkg::CPU_RESET;
			cfg_q.size_x         <= gccr_pkg::SIZE_RESET;
			cfg_q.size_y         <= gccr_pkg::SIZE_RESET;
			cfg_q.size_z         <= gccr_pkg::SIZE_RESET;
		end else if (cfg_wr) begin
			case (reg_idx)
				gccr_pkg::REG_CORNER_X: begin
					cfg_q.corner_x <= pwdata[gccr_pkg::COORD_W-1:0];
				end
				gccr_pkg::REG_CORNER_Y: begin
					cfg_q.corner_y <= pwdata[gccr_pkg::COORD_W-1:0];
				end
				gccr_pkg::REG_CORNER_Z: begin
					cfg_q.corner_z <= pwdata[gccr_pkg::COORD_W-1:0];
				end
				gccr_pkg::REG_CPU: begin
					cfg_q.cells_per_unit <= pwdata[gccr_pkg::CPU_W-1:0];
				end
				gccr_pkg::REG_SIZE_X: begin
					cfg_q.size_x <= pwdata[gccr_pkg::SIZE_W-1:0];
				end
				gccr_pkg::REG_SIZE_Y: begin
					cfg_q.size_y <= pwdata[gccr_pkg::SIZE_W-1:0];
				end
				gccr_pkg::REG_SIZE_Z: begin
					cfg_q.size_z <= pwdata[gccr_pkg::SIZE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// read back
	always_comb begin
		case (reg_idx)
			gccr_pkg::REG_CORNER_X: begin
				prdata = DW'(unsigned'(cfg_q.corner_x));
			end
			gccr_pkg::REG_CORNER_Y: begin
				prdata = DW'(unsigned'(cfg_q.corner_y));
			end
			gccr_pkg::REG_CORNER_Z: begin
				prdata = DW'(unsigned'(cfg_q.corner_z));
			end
			gccr_pkg::REG_CPU: begin
				prdata = DW'(cfg_q.cells_per_unit);
			end
			gccr_pkg::REG_SIZE_X: begin
				prdata = DW'(cfg_q.size_x);
			end
			gccr_pkg::REG_SIZE_Y: begin
				prdata = DW'(cfg_q.size_y);
			end
			gccr_pkg::REG_SIZE_Z: begin
				prdata = DW'(cfg_q.size_z);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	// front end: offsets, squares, classification
	gccr_front #(
		.MID_DEPTH(MID_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.axis_sel (axis_sel),
		.ref_x    (ref_x),
		.ref_y    (ref_y),
		.ref_z    (ref_z),
		.query_x  (query_x),
		.query_y  (query_y),
		.query_z  (query_z),
		.radius   (radius),
		.mid_count(mid_count),
		.mid_push (mid_push),
		.mid_data (mid_wdata)
	);

	// queue between front and back
	gccr_fifo #(
		.WIDTH(MW),
		.DEPTH(MID_DEPTH)
	) u_mid_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (mid_push),
		.wdata (mid_wdata),
		.pop   (mid_pop),
		.rdata (mid_rdata),
		.count (mid_count),
		.full  (mid_full),
		.empty (mid_empty)
	);

	// back end: square root and index mapping
	gccr_back #(
		.OUT_DEPTH(OUT_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.mid_empty(mid_empty),
		.mid_data (mid_rdata),
		.mid_pop  (mid_pop),
		.out_count(out_count),
		.out_push (out_push),
		.out_data (out_wdata)
	);

	// result queue
	gccr_fifo #(
		.WIDTH(OW),
		.DEPTH(OUT_DEPTH)
	) u_out_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (out_push),
		.wdata (out_wdata),
		.pop   (pop),
		.rdata (out_rdata),
		.count (out_count),
		.full  (out_full),
		.empty (empty)
	);

	assign empty_range = out_rdata.empty;
	assign first_cell  = out_rdata.first;
	assign last_cell   = out_rdata.last;

	// flow control keeps both queues from overrunning
	`GCCR_CHECK(a_mid_no_overrun, !(mid_push && mid_full))
	`GCCR_CHECK(a_out_no_overrun, !(out_push && out_full))
	// a result written is visible on the next cycle
	`GCCR_CHECK_NEXT(a_out_visible, out_push, !empty)
	// an empty chord always carries both markers
	`GCCR_CHECK(a_empty_markers, empty || !empty_range || (first_cell == gccr_pkg::FIRST_NONE && last_cell == gccr_pkg::LAST_NONE))

endmodule
